FILE: rtl/core/tkp_pkg.sv
// Shared types, constants and the base-2 exponent table of the top-k / top-p sampler.
`timescale 1ns / 1ps
`default_nettype none
package tkp_pkg;

    localparam int TKP_K_MAX     = 64;
    localparam int TKP_VOCAB_MAX = 131072;

    localparam logic [6:0]  TKP_TOP_K_RESET = 7'd40;
    localparam logic [16:0] TKP_TOP_P_RESET = 17'd58982;

    // Configuration register indexes
    localparam logic TKP_REG_TOP_K = 1'b0;
    localparam logic TKP_REG_TOP_P = 1'b1;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               last;
        logic [15:0]        random_draw;
    } t_tkp_req;

    typedef struct packed {
        logic [16:0] token_index;
        logic        fell_back;
    } t_tkp_res;

    // round(65536 * 2^(-j/16)) for j = 0..16
    function automatic logic [16:0] tkp_pow2(input logic [4:0] idx);
        logic [16:0] r;
        begin
            case (idx)
                5'd0:    r = 17'd65536;
                5'd1:    r = 17'd62757;
                5'd2:    r = 17'd60097;
                5'd3:    r = 17'd57549;
                5'd4:    r = 17'd55109;
                5'd5:    r = 17'd52773;
                5'd6:    r = 17'd50535;
                5'd7:    r = 17'd48393;
                5'd8:    r = 17'd46341;
                5'd9:    r = 17'd44376;
                5'd10:   r = 17'd42495;
                5'd11:   r = 17'd40693;
                5'd12:   r = 17'd38968;
                5'd13:   r = 17'd37316;
                5'd14:   r = 17'd35734;
                5'd15:   r = 17'd34219;
                5'd16:   r = 17'd32768;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tkp_front.sv
// Front request queue: accepts logit requests and buffers them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module tkp_front
    import tkp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_req_valid,
    output logic          o_req_ready,
    input  wire t_tkp_req i_req,
    output logic          o_q_valid,
    output t_tkp_req      o_q_item,
    input  wire logic     i_q_pop
);

    localparam int DEPTH = 4;
    localparam int AW    = 2;

    t_tkp_req       r_mem [DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [AW:0]    r_fill;
    logic           w_push;
    logic           w_pop;

    assign o_req_ready = (r_fill != (AW+1)'(DEPTH));
    assign o_q_valid   = (r_fill != '0);
    assign o_q_item    = r_mem[r_rptr];
    assign w_push      = i_req_valid && o_req_ready;
    assign w_pop       = i_q_pop && o_q_valid;

    // Store incoming requests
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            if (w_push && !w_pop) r_fill <= r_fill + 1'b1;
            else if (!w_push && w_pop) r_fill <= r_fill - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tkp_back.sv
// Back end: sorted insertion list, softmax weights, nucleus cut and draw selection.
`timescale 1ns / 1ps
`default_nettype none
module tkp_back
    import tkp_pkg::*;
#(
    parameter int K_MAX     = TKP_K_MAX,
    parameter int VOCAB_MAX = TKP_VOCAB_MAX
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [6:0]  i_top_k,
    input  wire logic [16:0] i_top_p,
    input  wire logic        i_q_valid,
    input  wire t_tkp_req    i_q_item,
    output logic             o_q_pop,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output t_tkp_res         o_res
);

    localparam int CW = $clog2(K_MAX + 1);
    localparam int IW = $clog2(VOCAB_MAX);
    localparam int SW = 18 + $clog2(K_MAX);

    typedef enum logic [3:0] {
        S_INS, S_W1A, S_W1B, S_W1C, S_W2A, S_W2B, S_W2C, S_DIV, S_CHK, S_OUT
    } t_state;

    t_state                r_state;
    logic signed [15:0]    r_val [K_MAX];
    logic [IW-1:0]         r_idx [K_MAX];
    logic [CW-1:0]         r_cnt;
    logic [IW-1:0]         r_pos;
    logic [CW-1:0]         r_step;
    logic signed [15:0]    r_max;
    logic [IW-1:0]         r_top_idx;
    logic [15:0]           r_draw;
    logic [16:0]           r_t;
    logic [16:0]           r_b;
    logic [4:0]            r_n;
    logic [SW-1:0]         r_sum;
    logic [SW-1:0]         r_rem;
    logic                  r_nb;
    logic [16:0]           r_quo;
    logic [4:0]            r_bit;
    logic [17:0]           r_cum;
    logic                  r_res_valid;
    t_tkp_res              r_res;
    t_tkp_res              r_pick;

    logic [CW-1:0]         w_k;
    logic [CW-1:0]         w_kept;
    logic                  w_ge [K_MAX];
    logic signed [15:0]    w_prv_val [K_MAX];
    logic [IW-1:0]         w_prv_idx [K_MAX];
    logic signed [15:0]    w_nxt_val [K_MAX];
    logic [IW-1:0]         w_nxt_idx [K_MAX];
    logic                  w_pop;
    logic [16:0]           w_d;
    logic [25:0]           w_prod;
    logic [8:0]            w_n;
    logic [3:0]            w_hi;
    logic [3:0]            w_lo;
    logic [22:0]           w_interp;
    logic [16:0]           w_e;
    logic [SW:0]           w_rem2;
    logic                  w_qbit;
    logic [17:0]           w_cum2;
    logic                  w_last_step;
    logic                  w_res_load;

    // Clamp the candidate count
    always_comb begin
        if (i_top_k == 7'd0) w_k = CW'(1);
        else if (32'(i_top_k) > K_MAX) w_k = CW'(K_MAX);
        else w_k = CW'(i_top_k);
        w_kept = (r_cnt > w_k) ? w_k : r_cnt;
    end

    // Compare the new logit against every stored entry; build neighbor views
    always_comb begin
        for (int j = 0; j < K_MAX; j++) begin
            w_ge[j] = (32'(j) < 32'(w_kept)) && (r_val[j] >= i_q_item.logit);
            w_prv_val[j] = (j == 0) ? r_val[0] : r_val[(j == 0) ? 0 : j - 1];
            w_prv_idx[j] = (j == 0) ? r_idx[0] : r_idx[(j == 0) ? 0 : j - 1];
            w_nxt_val[j] = r_val[(j == K_MAX - 1) ? 0 : j + 1];
            w_nxt_idx[j] = r_idx[(j == K_MAX - 1) ? 0 : j + 1];
        end
    end

    assign o_q_pop     = (r_state == S_INS) && i_q_valid;
    assign w_pop       = o_q_pop;
    assign w_last_step = (r_step == r_cnt - 1'b1);
    assign w_res_load  = (r_state == S_OUT) && (!r_res_valid || i_res_ready);

    // Exponent via base-2 distance and table interpolation; divider step; running sum
    always_comb begin
        w_d      = (r_step == '0) ? 17'd0 : 17'(r_max - r_val[0]);
        w_prod   = 26'(w_d[15:0]) * 26'd369 + 26'd128;
        w_n      = r_t[16:8];
        w_hi     = r_t[7:4];
        w_lo     = r_t[3:0];
        w_interp = 23'(tkp_pow2({1'b0, w_hi})) * 23'(5'd16 - {1'b0, w_lo})
                 + 23'(tkp_pow2(5'({1'b0, w_hi}) + 5'd1)) * 23'(w_lo) + 23'd8;
        w_e      = (r_n >= 5'd17) ? 17'd0 : (r_b >> r_n);
        w_rem2   = {r_rem, r_nb};
        w_qbit   = (w_rem2 >= {1'b0, r_sum});
        w_cum2   = r_cum + 18'(r_quo);
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // List storage: insert on each request, rotate during the final passes
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            for (int j = 0; j < K_MAX; j++) begin
                if (!w_ge[j]) begin
                    if (j == 0 || w_ge[(j == 0) ? 0 : j - 1]) begin
                        r_val[j] <= i_q_item.logit;
                        r_idx[j] <= r_pos;
                    end else begin
                        r_val[j] <= w_prv_val[j];
                        r_idx[j] <= w_prv_idx[j];
                    end
                end
            end
        end else if (r_state == S_W1C || (r_state == S_CHK && !(r_draw < w_cum2))) begin
            for (int j = 0; j < K_MAX; j++) begin
                if (32'(j) == 32'(r_cnt) - 1) begin
                    r_val[j] <= r_val[0];
                    r_idx[j] <= r_idx[0];
                end else begin
                    r_val[j] <= w_nxt_val[j];
                    r_idx[j] <= w_nxt_idx[j];
                end
            end
        end
    end

    // Load a finished pick into the output register; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_res_load) begin
            r_res_valid <= 1'b1;
            r_res       <= r_pick;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Sequencer for insertion, weight sum, division and selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INS;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_step      <= '0;
        end else begin
            unique case (r_state)
                S_INS: begin
                    if (w_pop) begin
                        r_cnt <= (w_kept < w_k) ? w_kept + 1'b1 : w_kept;
                        if (i_q_item.last) begin
                            r_pos   <= '0;
                            r_draw  <= i_q_item.random_draw;
                            r_step  <= '0;
                            r_sum   <= '0;
                            r_state <= S_W1A;
                        end else begin
                            r_pos <= (r_pos == IW'(VOCAB_MAX - 1)) ? '0 : r_pos + 1'b1;
                        end
                    end
                end
                S_W1A: begin
                    if (r_step == '0) begin
                        r_max     <= r_val[0];
                        r_top_idx <= r_idx[0];
                    end
                    r_t     <= w_prod[24:8];
                    r_state <= S_W1B;
                end
                S_W1B: begin
                    r_b     <= w_interp[20:4];
                    r_n     <= (w_n >= 9'd17) ? 5'd17 : w_n[4:0];
                    r_state <= S_W1C;
                end
                S_W1C: begin
                    r_sum <= r_sum + SW'(w_e);
                    if (w_last_step) begin
                        r_step  <= '0;
                        r_cum   <= '0;
                        r_state <= S_W2A;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_W1A;
                    end
                end
                S_W2A: begin
                    r_t     <= w_prod[24:8];
                    r_state <= S_W2B;
                end
                S_W2B: begin
                    r_b     <= w_interp[20:4];
                    r_n     <= (w_n >= 9'd17) ? 5'd17 : w_n[4:0];
                    r_state <= S_W2C;
                end
                S_W2C: begin
                    // Dividend is weight shifted up 16; its upper part seeds the remainder
                    r_rem   <= SW'(w_e >> 1);
                    r_nb    <= w_e[0];
                    r_quo   <= '0;
                    r_bit   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem   <= w_qbit ? SW'(w_rem2 - {1'b0, r_sum}) : w_rem2[SW-1:0];
                    r_nb    <= 1'b0;
                    r_quo   <= {r_quo[15:0], w_qbit};
                    r_bit   <= r_bit + 1'b1;
                    if (r_bit == 5'd16) r_state <= S_CHK;
                end
                S_CHK: begin
                    r_cum <= w_cum2;
                    if (r_draw < w_cum2) begin
                        r_pick.token_index <= 17'(r_idx[0]);
                        r_pick.fell_back   <= 1'b0;
                        r_state            <= S_OUT;
                    end else if (w_cum2 > 18'(i_top_p) || w_last_step) begin
                        r_pick.token_index <= 17'(r_top_idx);
                        r_pick.fell_back   <= 1'b1;
                        r_state            <= S_OUT;
                    end else begin
                        r_step  <= r_step + 1'b1;
                        r_state <= S_W2A;
                    end
                end
                S_OUT: begin
                    // Hold until the output slot frees
                    if (w_res_load) begin
                        r_cnt   <= '0;
                        r_state <= S_INS;
                    end
                end
                default: r_state <= S_INS;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/top_k_top_p_token_sampler.sv
// Top level of the top-k / top-p token sampler: config registers, front queue, back end.
//
// Usage: stream logits for token indices 0, 1, 2, ... on the request channel
// (i_req_valid / o_req_ready, payload i_req). The request with last = 1 closes
// the vocabulary; its random_draw selects the token. One result per vocabulary
// leaves on o_res_valid / i_res_ready / o_res.
// Throughput: the insertion list takes one logit per cycle while the back end is
// inserting. After the last logit the back end runs two passes over the n kept
// candidates: the weight sum (states W1A, W1B, W1C per entry), then, per entry until
// a pick is made, the exponent (W2A, W2B, W2C), a radix-2 divider for the 17-bit
// quotient and a check. A four-entry queue keeps taking requests meanwhile.
// Configuration: write top_k (index 0) and top_p (index 1) over the cfg channel
// while the block is idle; writes are always taken.
// Reset: synchronous, active low; clears the list, position and queue, and loads
// top_k = 40, top_p = 58982.
// A stalled receiver holds the result in the output register; the back end waits
// before placing the next result.
`timescale 1ns / 1ps
`default_nettype none
module top_k_top_p_token_sampler
    import tkp_pkg::*;
#(
    parameter int K_MAX     = TKP_K_MAX,
    parameter int VOCAB_MAX = TKP_VOCAB_MAX
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    input  wire t_tkp_req    i_req,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output t_tkp_res         o_res,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);

    logic [6:0]  r_top_k;
    logic [16:0] r_top_p;
    logic        w_q_valid;
    t_tkp_req    w_q_item;
    logic        w_q_pop;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_k <= TKP_TOP_K_RESET;
            r_top_p <= TKP_TOP_P_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                TKP_REG_TOP_K: r_top_k <= i_cfg_data[6:0];
                TKP_REG_TOP_P: r_top_p <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tkp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_q_pop     (w_q_pop)
    );

    tkp_back #(
        .K_MAX     (K_MAX),
        .VOCAB_MAX (VOCAB_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_top_k     (r_top_k),
        .i_top_p     (r_top_p),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
